// ----- rtl/cpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsc_pkg
// Types, constants and helpers shared by the clamped PID speed controller.
// ----------------------------------------------------------------------------
package cpsc_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Error and integral limits
  localparam logic signed [15:0] ERR_HI = 16'sd500;
  localparam logic signed [15:0] ERR_LO = -16'sd500;
  localparam logic signed [15:0] INT_HI = 16'sd10000;
  localparam logic signed [15:0] INT_LO = -16'sd10000;

  // Divide by ten: q = (x * ceil(2^35 / 10)) >> 35, exact for x below 2^32
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef enum logic [1:0] {
    REG_TARGET_SPEED = 2'd0,
    REG_GAIN_P       = 2'd1,
    REG_GAIN_I       = 2'd2,
    REG_GAIN_D       = 2'd3
  } cpsc_reg_e;

  typedef struct packed {
    logic signed [14:0] target_speed;
    logic signed [15:0] gain_proportional;
    logic signed [15:0] gain_integral;
    logic signed [15:0] gain_derivative;
  } cpsc_cfg_t;

  // First stage: clamped error, updated integral, error change
  typedef struct packed {
    logic signed [9:0]  err;
    logic signed [14:0] integ;
    logic signed [10:0] err_delta;
  } cpsc_err_t;

  // Second stage: P and D products, integral product as sign and magnitude
  typedef struct packed {
    logic signed [25:0] p_term;
    logic signed [26:0] d_term;
    logic        [29:0] i_mag;
    logic               i_neg;
  } cpsc_prod_t;

  // Third stage: integral product divided by ten
  typedef struct packed {
    logic signed [25:0] p_term;
    logic signed [26:0] d_term;
    logic        [25:0] i_quot;
    logic               i_neg;
  } cpsc_quot_t;

  function automatic logic signed [9:0] clamp_err(input logic signed [15:0] v);
    logic signed [9:0] r;
    if (v > ERR_HI) begin
      r = ERR_HI[9:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[9:0];
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  function automatic logic signed [14:0] clamp_int(input logic signed [15:0] v);
    logic signed [14:0] r;
    if (v > INT_HI) begin
      r = INT_HI[14:0];
    end else if (v < INT_LO) begin
      r = INT_LO[14:0];
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/cpsc_ifs.sv -----
// ----------------------------------------------------------------------------
// cpsc_ifs
// Valid/ready channels for measured speed samples and drive values.
// ----------------------------------------------------------------------------
interface cpsc_meas_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] measured_speed;

  modport source (output valid, output measured_speed, input ready);
  modport sink   (input valid, input measured_speed, output ready);
endinterface

interface cpsc_drive_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

// ----- rtl/cpsc_apb_regs.sv -----
// ----------------------------------------------------------------------------
// cpsc_apb_regs
// APB register file for setpoint and PID gains.
// ----------------------------------------------------------------------------
module cpsc_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [cpsc_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [cpsc_pkg::DATA_W-1:0]  pwdata_i,
  output logic [cpsc_pkg::DATA_W-1:0]  prdata_o,
  output cpsc_pkg::cpsc_cfg_t          cfg_o
);
  import cpsc_pkg::*;

  cpsc_cfg_t cfg_q, cfg_d;
  cpsc_reg_e reg_sel;
  logic      wr_en;

  assign reg_sel = cpsc_reg_e'(paddr_i[3:2]);
  assign wr_en   = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_TARGET_SPEED: cfg_d.target_speed      = pwdata_i[14:0];
        REG_GAIN_P:       cfg_d.gain_proportional = pwdata_i[15:0];
        REG_GAIN_I:       cfg_d.gain_integral     = pwdata_i[15:0];
        REG_GAIN_D:       cfg_d.gain_derivative   = pwdata_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TARGET_SPEED: prdata_o = DATA_W'(cfg_q.target_speed);
      REG_GAIN_P:       prdata_o = DATA_W'(cfg_q.gain_proportional);
      REG_GAIN_I:       prdata_o = DATA_W'(cfg_q.gain_integral);
      REG_GAIN_D:       prdata_o = DATA_W'(cfg_q.gain_derivative);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/cpsc_err_stage.sv -----
// ----------------------------------------------------------------------------
// cpsc_err_stage
// Input register: clamp the error, update the integral, form the error change.
// ----------------------------------------------------------------------------
module cpsc_err_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [14:0]   target_speed_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [14:0]   measured_speed_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cpsc_pkg::cpsc_err_t  data_o
);
  import cpsc_pkg::*;

  logic               valid_q;
  cpsc_err_t          data_q, data_d;
  logic signed [9:0]  prev_err_q;
  logic signed [14:0] integ_q;
  logic signed [15:0] raw_err;
  logic signed [9:0]  err;
  logic signed [14:0] integ_new;
  logic               take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  assign raw_err   = 16'(target_speed_i) - 16'(measured_speed_i);
  assign err       = clamp_err(raw_err);
  assign integ_new = clamp_int(16'(integ_q) + 16'(err));

  always_comb begin
    data_d.err       = err;
    data_d.integ     = integ_new;
    data_d.err_delta = 11'(err) - 11'(prev_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      prev_err_q <= '0;
      integ_q    <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        prev_err_q <= err;
        integ_q    <= integ_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/cpsc_mul_stage.sv -----
// ----------------------------------------------------------------------------
// cpsc_mul_stage
// Gain products, then the integral product scaled by the reciprocal of ten.
// ----------------------------------------------------------------------------
module cpsc_mul_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cpsc_pkg::cpsc_cfg_t  cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cpsc_pkg::cpsc_err_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cpsc_pkg::cpsc_quot_t data_o
);
  import cpsc_pkg::*;

  logic        prod_valid_q, quot_valid_q;
  logic        prod_ready, quot_ready;
  cpsc_prod_t  prod_q, prod_d;
  cpsc_quot_t  quot_q, quot_d;
  logic [15:0] ki_mag;
  logic [13:0] integ_mag;
  logic [61:0] scaled;

  assign quot_ready = !quot_valid_q || ready_i;
  assign prod_ready = !prod_valid_q || quot_ready;
  assign ready_o    = prod_ready;

  // Take the integral product as sign and magnitude so the divide stays unsigned
  always_comb begin
    ki_mag    = cfg_i.gain_integral[15] ? 16'(-cfg_i.gain_integral)
                                        : cfg_i.gain_integral;
    integ_mag = data_i.integ[14] ? 14'(-data_i.integ) : data_i.integ[13:0];
    prod_d.p_term = 26'(cfg_i.gain_proportional) * 26'(data_i.err);
    prod_d.d_term = 27'(cfg_i.gain_derivative) * 27'(data_i.err_delta);
    prod_d.i_mag  = 30'(ki_mag) * 30'(integ_mag);
    prod_d.i_neg  = cfg_i.gain_integral[15] ^ data_i.integ[14];
  end

  assign scaled = 62'(prod_q.i_mag) * 62'(DIV10_MUL);

  always_comb begin
    quot_d.p_term = prod_q.p_term;
    quot_d.d_term = prod_q.d_term;
    quot_d.i_quot = scaled[DIV10_SHIFT +: 26];
    quot_d.i_neg  = prod_q.i_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= valid_i;
      end
      if (quot_ready) begin
        quot_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && prod_ready) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q && quot_ready) begin
      quot_q <= quot_d;
    end
  end

  assign valid_o = quot_valid_q;
  assign data_o  = quot_q;

endmodule

// ----- rtl/cpsc_sum_stage.sv -----
// ----------------------------------------------------------------------------
// cpsc_sum_stage
// Output register: apply the integral sign and add the three terms.
// ----------------------------------------------------------------------------
module cpsc_sum_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cpsc_pkg::cpsc_quot_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [27:0]   drive_value_o
);
  import cpsc_pkg::*;

  logic               valid_q;
  logic signed [27:0] drive_q, drive_d;
  logic signed [27:0] i_term;

  assign ready_o = !valid_q || ready_i;

  // Quotient of the magnitude, then negate: truncates toward zero
  assign i_term  = data_i.i_neg ? -28'(data_i.i_quot) : 28'(data_i.i_quot);
  assign drive_d = 28'(data_i.p_term) + 28'(data_i.d_term) + i_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      drive_q <= drive_d;
    end
  end

  assign valid_o       = valid_q;
  assign drive_value_o = drive_q;

endmodule

// ----- rtl/clamped_pid_speed_controller.sv -----
// A result passes the error, product, quotient and sum registers in order once its sample beat is accepted.
// Throughput: one sample per cycle while the drive sink takes every beat; the integral
//   add-and-clamp in the first stage closes the only loop.
// Each stage has its own valid, so a stalled result leaves earlier stages free.
// Reset clears the config registers, the previous error, the integral and all valids, not the data registers.
// ----------------------------------------------------------------------------
// clamped_pid_speed_controller
// Positional PID on speed samples with clamped error and clamped integral.
// ----------------------------------------------------------------------------
module clamped_pid_speed_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpsc_pkg::DATA_W-1:0]  pwdata,
  output logic [cpsc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  cpsc_meas_if.sink                    meas_i,
  cpsc_drive_if.source                 drive_o
);
  import cpsc_pkg::*;

  cpsc_cfg_t  cfg;
  cpsc_err_t  err_data;
  cpsc_quot_t quot_data;
  logic       err_valid, err_ready;
  logic       quot_valid, quot_ready;

  assign pready = 1'b1;

  cpsc_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  cpsc_err_stage u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .target_speed_i   (cfg.target_speed),
    .valid_i          (meas_i.valid),
    .ready_o          (meas_i.ready),
    .measured_speed_i (meas_i.measured_speed),
    .valid_o          (err_valid),
    .ready_i          (err_ready),
    .data_o           (err_data)
  );

  cpsc_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .data_i  (err_data),
    .valid_o (quot_valid),
    .ready_i (quot_ready),
    .data_o  (quot_data)
  );

  cpsc_sum_stage u_sum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (quot_valid),
    .ready_o       (quot_ready),
    .data_i        (quot_data),
    .valid_o       (drive_o.valid),
    .ready_i       (drive_o.ready),
    .drive_value_o (drive_o.drive_value)
  );

endmodule

// ----- rtl/cpsc_checker.sv -----
// ----------------------------------------------------------------------------
// cpsc_checker
// Port-level checks on the controller's sample and drive channels.
// ----------------------------------------------------------------------------
module cpsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [27:0] drive_value_i
);

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_i;

  // An empty output register frees every stage behind it
  a_ready_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i
  ) else $error("sample channel stalled with empty output");

  // With the sink taking every beat, a sample moves through the stages and reaches the output
  a_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_beat ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i
  ) else $error("drive value missing after accepted sample");

  a_valid_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
  ) else $error("drive valid dropped while stalled");

  a_data_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_value_i)
  ) else $error("drive value changed while stalled");

endmodule

bind clamped_pid_speed_controller cpsc_checker u_cpsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (meas_i.valid),
  .in_ready_i    (meas_i.ready),
  .out_valid_i   (drive_o.valid),
  .out_ready_i   (drive_o.ready),
  .drive_value_i (drive_o.drive_value)
);

// ----- sim/clamped_pid_speed_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clamped_pid_speed_controller_tb
// Self-checking bench for the clamped PID speed controller. Programs setpoint
// and gains over the register port while the pipe is empty, streams speed
// samples with random gaps and back-pressure, and compares every drive beat
// against an in-bench PID predictor that tracks error history and integral.
// ----------------------------------------------------------------------------

// Tracks the controller state and holds the drive values still owed.
class pid_drive_scoreboard;
  localparam int ERR_LIM = 500;
  localparam int INT_LIM = 10000;
  localparam int INT_DIV = 10;
  localparam int MAX_REPORTS = 10;

  int target_speed;
  int kp;
  int ki;
  int kd;
  int last_err;
  int err_sum;
  logic [27:0] drive_q[$];
  int n_samples;
  int n_checked;
  int n_fail;

  function new();
    target_speed = 0;
    kp = 0;
    ki = 0;
    kd = 0;
    last_err = 0;
    err_sum = 0;
    n_samples = 0;
    n_checked = 0;
    n_fail = 0;
  endfunction

  function void set_register(cpsc_pkg::cpsc_reg_e idx, logic [31:0] v);
    case (idx)
      cpsc_pkg::REG_TARGET_SPEED: target_speed = int'($signed(v[14:0]));
      cpsc_pkg::REG_GAIN_P:       kp = int'($signed(v[15:0]));
      cpsc_pkg::REG_GAIN_I:       ki = int'($signed(v[15:0]));
      cpsc_pkg::REG_GAIN_D:       kd = int'($signed(v[15:0]));
      default: ;
    endcase
  endfunction

  function int pending();
    return drive_q.size();
  endfunction

  // Advance the PID state by one sample and queue the drive it must produce.
  function void note_sample(logic signed [14:0] speed);
    int err;
    int sum;
    err = target_speed - int'(speed);
    if (err > ERR_LIM) err = ERR_LIM;
    else if (err < -ERR_LIM) err = -ERR_LIM;
    err_sum = err_sum + err;
    if (err_sum > INT_LIM) err_sum = INT_LIM;
    else if (err_sum < -INT_LIM) err_sum = -INT_LIM;
    // signed int division truncates toward zero
    sum = kp * err + (ki * err_sum) / INT_DIV + kd * (err - last_err);
    last_err = err;
    drive_q.push_back(sum[27:0]);
    n_samples++;
  endfunction

  function void flag(string what, logic [27:0] want, logic [27:0] got);
    n_fail++;
    if (n_fail <= MAX_REPORTS) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
    end
  endfunction

  function void check_drive(logic [27:0] got);
    logic [27:0] want;
    n_checked++;
    if (drive_q.size() == 0) begin
      flag("drive beat with nothing owed", 'x, got);
    end else begin
      want = drive_q.pop_front();
      if (got !== want) begin
        flag("drive_value mismatch", want, got);
      end
    end
  endfunction
endclass

module clamped_pid_speed_controller_tb;
  import cpsc_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int PIPE_LATENCY = 3;
  localparam int NUM_PHASES = 14;
  localparam int PHASE_ITEMS = 124;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_WAIT = 17;

  localparam logic signed [14:0] EDGE_SPEEDS [10] = '{
    15'sd16383, -15'sd16384, 15'sd10000, -15'sd10000, 15'sd500,
    -15'sd500, 15'sd501, -15'sd501, 15'sd0, 15'sd499
  };

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic             pready;

  cpsc_meas_if  meas_ch ();
  cpsc_drive_if drive_ch ();

  pid_drive_scoreboard sb = new();

  int  tx_mode;
  int  rx_mode;
  bit  hold_rx;
  int  cur_target;
  int  n_reg_writes;

  clamped_pid_speed_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .meas_i  (meas_ch),
    .drive_o (drive_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mode 0: no idling, 1: uniform, 2: mostly back-to-back
  function automatic int draw_wait(int mode);
    int w;
    case (mode)
      0: w = 0;
      1: w = $urandom_range(0, MAX_WAIT);
      default: w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
    return w;
  endfunction

  function automatic int pick_gain();
    int g;
    case ($urandom_range(0, 5))
      0: g = -32768;
      1: g = 32767;
      2: g = 0;
      3: g = int'($urandom_range(0, 40)) - 20;
      default: g = int'($signed(16'($urandom)));
    endcase
    return g;
  endfunction

  function automatic int pick_target();
    int t;
    case ($urandom_range(0, 5))
      0: t = -16384;
      1: t = 16383;
      2: t = $urandom_range(0, 1) ? 10000 : -10000;
      3: t = 0;
      default: t = int'($signed(15'($urandom)));
    endcase
    return t;
  endfunction

  // Mostly samples around a biased error so the integral drifts into its clamp.
  function automatic logic signed [14:0] next_speed(int bias);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 1) ? 16383 : -16384;
      default: v = cur_target - bias + int'($urandom_range(0, 400)) - 200;
    endcase
    return v[14:0];
  endfunction

  // Leaves psel and penable high; the caller drops them after the last write.
  task automatic write_reg(cpsc_reg_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    n_reg_writes++;
  endtask

  task automatic program_gains(int target, int gp, int gi, int gd);
    write_reg(REG_TARGET_SPEED, target);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_target = target;
  endtask

  // Keep valid high across back-to-back beats; drop it only for a gap.
  task automatic send_sample(logic signed [14:0] speed);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      meas_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas_ch.valid          <= 1'b1;
    meas_ch.measured_speed <= speed;
    do @(posedge clk_i); while (!meas_ch.ready);
  endtask

  task automatic wait_idle();
    // let the monitor log the last accepted beat before counting what is owed
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Receiver: stall for a random wait, or for the long hold-off when hold_rx is set, then take one beat.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(rx_mode);
      end
      if (stall > 0) begin
        drive_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      drive_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!drive_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (meas_ch.valid && meas_ch.ready) begin
        sb.note_sample(meas_ch.measured_speed);
      end
      if (drive_ch.valid && drive_ch.ready) begin
        sb.check_drive(drive_ch.drive_value);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d drive values outstanding", cycles, sb.pending());
    $display("clamped_pid_speed_controller regression: fail");
    $finish;
  end

  initial begin
    int bias;
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    meas_ch.valid          = 1'b0;
    meas_ch.measured_speed = '0;
    drive_ch.ready         = 1'b0;
    tx_mode                = 1;
    rx_mode                = 1;
    hold_rx                = 1'b0;
    cur_target             = 0;
    n_reg_writes           = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all gains zero, first sample sees no previous error.
    send_sample(15'sd0);
    send_sample(-15'sd16384);
    meas_ch.valid <= 1'b0;
    wait_idle();

    // Small odd gains expose truncation of the integral term.
    program_gains(0, 3, 7, -5);
    foreach (EDGE_SPEEDS[k]) send_sample(EDGE_SPEEDS[k]);
    meas_ch.valid <= 1'b0;
    wait_idle();

    // Most negative gains with error swinging between both clamps.
    program_gains(10000, -32768, -32768, -32768);
    repeat (4) begin
      send_sample(15'sd16383);
      send_sample(-15'sd16384);
    end
    send_sample(15'sd10000);
    send_sample(15'sd9500);
    meas_ch.valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        program_gains(16383, 32767, 32767, 32767);
      end else if (ph == 1) begin
        program_gains(-16384, -32768, -32768, -32768);
      end else begin
        program_gains(pick_target(), pick_gain(), pick_gain(), pick_gain());
      end
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      bias = int'($urandom_range(0, 1400)) - 700;
      if (ph == PRESSURE_PHASE) begin
        // back the pipe up against a long receiver hold-off
        tx_mode = 0;
        hold_rx = 1'b1;
      end
      repeat (PHASE_ITEMS) send_sample(next_speed(bias));
      meas_ch.valid <= 1'b0;
      wait_idle();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
    $display("covered %0d speed samples over %0d gain settings (%0d register writes)",
             sb.n_samples, NUM_PHASES + 2, n_reg_writes);
    $display("checked %0d drive beats, %0d mismatches", sb.n_checked, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("clamped_pid_speed_controller regression: pass");
    end else begin
      $display("clamped_pid_speed_controller regression: fail");
    end
    $finish;
  end

endmodule
